### hw/rtl/button_debounce_event_detector_assert.svh
// assertion macros for the debounce block rtl
`ifndef BUTTON_DEBOUNCE_EVENT_DETECTOR_ASSERT_SVH
`define BUTTON_DEBOUNCE_EVENT_DETECTOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define BDD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bdd assertion failed");
`define BDD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bdd implication failed");
`define BDD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bdd next-cycle check failed");
`else
`define BDD_ASSERT(label, prop)
`define BDD_ASSERT_IMPL(label, ante, cons)
`define BDD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hw/rtl/bdd_pkg.sv
// types and constants of the button debounce event detector
package bdd_pkg;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_LONG    = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    CFG_ACTIVE_LOW  = 2'd0,
    CFG_DEBOUNCE_MS = 2'd1,
    CFG_HOLD_MS     = 2'd2,
    CFG_REPEAT_MS   = 2'd3
  } cfg_index_e;

  localparam int unsigned TimeW = 32;
  localparam int unsigned InTdataW = 40;

  localparam logic [TimeW-1:0] DebounceReset = 32'd50;
  localparam logic [TimeW-1:0] HoldReset     = 32'd2000;
  localparam logic [TimeW-1:0] RepeatReset   = 32'd0;

  // configuration seen by the event core
  typedef struct packed {
    logic             active_low;
    logic [TimeW-1:0] debounce_ms;
    logic [TimeW-1:0] hold_ms;
    logic [TimeW-1:0] repeat_ms;
  } cfg_t;

  // one result item, laid out as it travels in tdata (event_code lowest)
  typedef struct packed {
    logic   pressed;
    logic   on_hold;
    logic   repeat_click;
    logic   click;
    event_e event_code;
  } result_t;

endpackage

### hw/rtl/bdd_core.sv
// debounce state and per-sample event logic
module bdd_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bdd_pkg::cfg_t               cfg_i,
  input  logic                        take_i,
  input  logic                        raw_level_i,
  input  logic [bdd_pkg::TimeW-1:0]   now_ms_i,
  output bdd_pkg::result_t            result_o
);

  logic                      accepted_level_q, accepted_level_d;
  logic [bdd_pkg::TimeW-1:0] last_change_q, last_change_d;
  logic [bdd_pkg::TimeW-1:0] last_repeat_q, last_repeat_d;
  bdd_pkg::event_e           last_event_q, last_event_d;

  logic                      level;
  logic [bdd_pkg::TimeW-1:0] since_change;
  logic [bdd_pkg::TimeW-1:0] since_repeat;
  logic                      changed;
  logic                      bounce;
  logic                      holding;
  logic                      repeat_due;

  // elapsed times wrap modulo 2^32
  assign level        = raw_level_i ^ cfg_i.active_low;
  assign since_change = now_ms_i - last_change_q;
  assign since_repeat = now_ms_i - last_repeat_q;
  assign changed      = level != accepted_level_q;
  assign bounce       = since_change < cfg_i.debounce_ms;
  assign holding      = !changed && level && (since_change > cfg_i.hold_ms);
  assign repeat_due   = holding && (cfg_i.repeat_ms != '0) && (since_repeat > cfg_i.repeat_ms);

  // result fields and next state
  always_comb begin
    result_o              = '0;
    result_o.event_code   = bdd_pkg::EV_NONE;
    result_o.pressed      = level;
    accepted_level_d      = accepted_level_q;
    last_change_d         = last_change_q;
    last_repeat_d         = last_repeat_q;
    last_event_d          = last_event_q;
    if (changed) begin
      last_change_d = now_ms_i;
      if (!bounce) begin
        accepted_level_d = level;
        if (level) begin
          result_o.event_code = bdd_pkg::EV_PRESS;
          last_event_d        = bdd_pkg::EV_PRESS;
        end else begin
          result_o.event_code = bdd_pkg::EV_RELEASE;
          result_o.click      = last_event_q == bdd_pkg::EV_PRESS;
          last_event_d        = bdd_pkg::EV_RELEASE;
        end
      end
    end else if (holding) begin
      result_o.event_code   = bdd_pkg::EV_LONG;
      result_o.on_hold      = 1'b1;
      result_o.repeat_click = repeat_due;
      last_event_d          = bdd_pkg::EV_LONG;
      if (repeat_due) begin
        last_repeat_d = now_ms_i;
      end
    end
  end

  // state advances on every input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accepted_level_q <= 1'b0;
      last_change_q    <= '0;
      last_repeat_q    <= '0;
      last_event_q     <= bdd_pkg::EV_NONE;
    end else if (take_i) begin
      accepted_level_q <= accepted_level_d;
      last_change_q    <= last_change_d;
      last_repeat_q    <= last_repeat_d;
      last_event_q     <= last_event_d;
    end
  end

endmodule

### hw/rtl/button_debounce_event_detector.sv
// Button debounce and event detector, top level with stream ports.
// Each result is registered: it goes to the output register, or to the one-entry skid
// stage while the output stalls. Throughput: one sample per cycle when the output
// is not stalled; input ready is registered, as it is the inverse of the skid valid.
// Reset (rst_ni low, asynchronous) clears the debounce state, empties the
// output stages and returns the configuration registers to their defaults.
`include "button_debounce_event_detector_assert.svh"

module button_debounce_event_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // sample input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [0] raw_level, [32:1] now_ms, [39:33] zero
  // event output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // [1:0] event_code, [2] click, [3] repeat_click,
                                     // [4] on_hold, [5] pressed, [7:6] zero
);

  bdd_pkg::cfg_t    cfg_q;
  bdd_pkg::result_t result;
  bdd_pkg::result_t out_q;
  bdd_pkg::result_t skid_q;
  logic             out_valid_q;
  logic             skid_valid_q;
  logic             in_xfer;
  logic             out_xfer;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !skid_valid_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_low  <= 1'b0;
      cfg_q.debounce_ms <= bdd_pkg::DebounceReset;
      cfg_q.hold_ms     <= bdd_pkg::HoldReset;
      cfg_q.repeat_ms   <= bdd_pkg::RepeatReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bdd_pkg::cfg_index_e'(cfg_index_i))
        bdd_pkg::CFG_ACTIVE_LOW:  cfg_q.active_low  <= cfg_data_i[0];
        bdd_pkg::CFG_DEBOUNCE_MS: cfg_q.debounce_ms <= cfg_data_i;
        bdd_pkg::CFG_HOLD_MS:     cfg_q.hold_ms     <= cfg_data_i;
        bdd_pkg::CFG_REPEAT_MS:   cfg_q.repeat_ms   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bdd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .take_i      (in_xfer),
    .raw_level_i (s_axis_tdata[0]),
    .now_ms_i    (s_axis_tdata[32:1]),
    .result_o    (result)
  );

  // output register and skid stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_xfer) begin
        out_valid_q  <= skid_valid_q || in_xfer;
        skid_valid_q <= 1'b0;
      end else if (in_xfer) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_xfer) begin
      out_q <= skid_valid_q ? skid_q : result;
    end else if (in_xfer) begin
      skid_q <= result;
    end
  end

  `BDD_ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q)
  `BDD_ASSERT_NEXT(a_stall_fills_skid, in_xfer && out_valid_q && !m_axis_tready, skid_valid_q)
  `BDD_ASSERT_IMPL(a_hold_is_long, out_valid_q && out_q.on_hold, (out_q.event_code == bdd_pkg::EV_LONG) && out_q.pressed)
  `BDD_ASSERT_IMPL(a_click_on_release, out_valid_q && out_q.click, out_q.event_code == bdd_pkg::EV_RELEASE)

endmodule

### tb/button_debounce_event_detector_test.sv
// self-checking testbench for the button debounce event detector
`timescale 1ns / 100ps

module button_debounce_event_detector_test;

  // predicts the event stream and holds expected results in arrival order
  class debounce_scoreboard;
    bit                   act_low;
    logic [31:0]          debounce_ms;
    logic [31:0]          hold_ms;
    logic [31:0]          repeat_ms;
    bit                   level_q;
    logic [31:0]          change_t;
    logic [31:0]          repeat_t;
    bdd_pkg::event_e      last_ev;
    bdd_pkg::result_t     expected_q[$];
    int unsigned          errors;

    function new();
      act_low     = 1'b0;
      debounce_ms = bdd_pkg::DebounceReset;
      hold_ms     = bdd_pkg::HoldReset;
      repeat_ms   = bdd_pkg::RepeatReset;
      level_q     = 1'b0;
      change_t    = '0;
      repeat_t    = '0;
      last_ev     = bdd_pkg::EV_NONE;
      errors      = 0;
    endfunction

    function void set_register(bdd_pkg::cfg_index_e idx, logic [31:0] value);
      case (idx)
        bdd_pkg::CFG_ACTIVE_LOW:  act_low = value[0];
        bdd_pkg::CFG_DEBOUNCE_MS: debounce_ms = value;
        bdd_pkg::CFG_HOLD_MS:     hold_ms = value;
        bdd_pkg::CFG_REPEAT_MS:   repeat_ms = value;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // note one accepted sample and queue the event it must produce
    function void note_sample(bit raw, logic [31:0] now);
      bit               lvl;
      logic [31:0]      since_change;
      logic [31:0]      since_repeat;
      bdd_pkg::result_t r;
      lvl          = raw ^ act_low;
      since_change = now - change_t;
      since_repeat = now - repeat_t;
      r            = '0;
      r.event_code = bdd_pkg::EV_NONE;
      r.pressed    = lvl;
      if (lvl != level_q) begin
        // bounce only refreshes the change time
        if (since_change >= debounce_ms) begin
          r.event_code = lvl ? bdd_pkg::EV_PRESS : bdd_pkg::EV_RELEASE;
          r.click      = !lvl && (last_ev == bdd_pkg::EV_PRESS);
          last_ev      = r.event_code;
          level_q      = lvl;
        end
        change_t = now;
      end else if (lvl && since_change > hold_ms) begin
        r.event_code = bdd_pkg::EV_LONG;
        r.on_hold    = 1'b1;
        if (repeat_ms != 0 && since_repeat > repeat_ms) begin
          r.repeat_click = 1'b1;
          repeat_t       = now;
        end
        last_ev = bdd_pkg::EV_LONG;
      end
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      $display("%0t mismatch on %s: got %0d expected %0d", $time, what, got, want);
    endtask

    // compare one output transfer against the oldest expectation
    task check_result(logic [7:0] tdata);
      bdd_pkg::result_t got;
      bdd_pkg::result_t want;
      got = bdd_pkg::result_t'(tdata[5:0]);
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", int'(tdata), 0);
      end else begin
        want = expected_q.pop_front();
        if (got.event_code != want.event_code)
          report_mismatch("event_code", int'(got.event_code), int'(want.event_code));
        if (got.click != want.click)
          report_mismatch("click", int'(got.click), int'(want.click));
        if (got.repeat_click != want.repeat_click)
          report_mismatch("repeat_click", int'(got.repeat_click), int'(want.repeat_click));
        if (got.on_hold != want.on_hold)
          report_mismatch("on_hold", int'(got.on_hold), int'(want.on_hold));
        if (got.pressed != want.pressed)
          report_mismatch("pressed", int'(got.pressed), int'(want.pressed));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = bdd_pkg::CFG_ACTIVE_LOW;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  debounce_scoreboard sb = new();

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned items_sent = 0;
  int unsigned hold_off_req = 0;
  int unsigned hold_off_seen = 0;
  int unsigned hold_off_left = 0;
  logic [31:0] now_cursor = '0;
  bit          pin = 1'b0;

  button_debounce_event_detector u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // output side: check each transfer, then pick the next ready value
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (hold_off_req != hold_off_seen) begin
      hold_off_seen = hold_off_req;
      hold_off_left = 300;
    end
    if (hold_off_left != 0) begin
      hold_off_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // one sample transfer, with random idle cycles ahead of it
  task automatic send_sample(input bit raw, input logic [31:0] now);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, now, raw};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_sample(raw, now);
    items_sent++;
  endtask

  task automatic write_reg(input bdd_pkg::cfg_index_e idx, input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_register(idx, value);
  endtask

  // drain the block, then load all four registers
  task automatic program_cfg(input bit al, input logic [31:0] deb, input logic [31:0] hold,
                             input logic [31:0] rep);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    write_reg(bdd_pkg::CFG_ACTIVE_LOW, {31'd0, al});
    write_reg(bdd_pkg::CFG_DEBOUNCE_MS, deb);
    write_reg(bdd_pkg::CFG_HOLD_MS, hold);
    write_reg(bdd_pkg::CFG_REPEAT_MS, rep);
    cfg_valid_i <= 1'b0;
  endtask

  // button gestures: bounce burst, then a steady level; some pure noise
  task automatic run_gestures(input int unsigned n, input logic [31:0] span);
    int unsigned start;
    int unsigned bounces;
    int unsigned steady;
    start      = items_sent;
    now_cursor = $urandom;
    while (items_sent - start < n) begin
      if ($urandom_range(9) == 0) begin
        send_sample(1'($urandom_range(1)), $urandom);
      end else begin
        pin     = ~pin;
        bounces = $urandom_range(3);
        steady  = $urandom_range(1, 6);
        repeat (bounces) begin
          now_cursor += $urandom_range(span / 4);
          send_sample(1'($urandom_range(1)), now_cursor);
        end
        repeat (steady) begin
          now_cursor += $urandom_range(2 * span);
          send_sample(pin, now_cursor);
        end
      end
    end
  endtask

  initial begin
    #(2_000_000);
    $display("[button_debounce_event_detector] ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 8;
    snk_idle_pct = 46;

    // reset settings: bounce, exact hold threshold, long press, click, wrap
    send_sample(1'b0, 32'd0);
    send_sample(1'b1, 32'd10);
    send_sample(1'b1, 32'd60);
    send_sample(1'b0, 32'd70);
    send_sample(1'b1, 32'd2070);
    send_sample(1'b1, 32'd2071);
    send_sample(1'b0, 32'd2200);
    send_sample(1'b1, 32'd2300);
    send_sample(1'b0, 32'd2350);
    send_sample(1'b1, 32'hFFFF_FFF0);
    send_sample(1'b0, 32'h0000_0020);
    send_sample(1'b0, 32'h0000_0052);

    // inverted input, no debounce, repeat with exact threshold
    program_cfg(1'b1, 32'd0, 32'd10, 32'd5);
    send_sample(1'b1, 32'h100);
    send_sample(1'b0, 32'h101);
    send_sample(1'b0, 32'h10B);
    send_sample(1'b0, 32'h10C);
    send_sample(1'b0, 32'h111);
    send_sample(1'b0, 32'h112);
    send_sample(1'b1, 32'h112);

    // all times at their maximum
    program_cfg(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(1'b1, 32'h200);
    send_sample(1'b1, 32'h1FF);
    send_sample(1'b1, 32'h1FE);
    send_sample(1'b0, 32'h1FE);

    // random gestures under several settings
    program_cfg(1'b0, 32'd20, 32'd100, 32'd30);
    run_gestures(200, 32'd40);
    program_cfg(1'b1, 32'd5, 32'd40, 32'd0);
    hold_off_req <= hold_off_req + 1;
    run_gestures(200, 32'd15);

    src_idle_pct = 46;
    snk_idle_pct = 8;
    program_cfg(1'b0, 32'd0, 32'd0, 32'd1);
    run_gestures(200, 32'd3);
    program_cfg(1'b1, $urandom_range(30), $urandom_range(60), $urandom_range(20));
    run_gestures(200, 32'd20);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    program_cfg(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_gestures(150, 32'h7FFF_FFFF);
    program_cfg(1'b1, 32'd50, 32'd2000, 32'd250);
    run_gestures(200, 32'd600);

    // drain and let any stray result show up
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[button_debounce_event_detector] OK");
    end else begin
      $display("[button_debounce_event_detector] ERROR");
    end
    $finish;
  end

endmodule
